/* hw/rtl/leps_pkg.sv */
// ----------------------------------------------------------------------------
// leps_pkg: shared types and constants
// Word formats, status and function codes, and the sequencer states of the
// looped event pattern scheduler.
// ----------------------------------------------------------------------------
package leps_pkg;

    localparam int TICK_W = 32;
    localparam int PAY_W  = 24;

    localparam int PATTERN_DEPTH_DEF = 32;
    localparam int OUT_CAP_DEF       = 64;
    localparam int PAYLOAD_BITS_DEF  = 24;

    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;
    localparam logic [1:0] FN_RSVD   = 2'd3;

    localparam logic [1:0] STAT_EVENT  = 2'd0;
    localparam logic [1:0] STAT_ACCEPT = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;
    localparam logic [1:0] STAT_TRUNC  = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [TICK_W-1:0] event_tick;
        logic [PAY_W-1:0]  event_payload;
        logic [TICK_W-1:0] range_start;
        logic [TICK_W-1:0] range_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TICK_W-1:0] out_tick;
        logic [PAY_W-1:0]  out_payload;
        logic              last;
    } out_word_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [PAY_W-1:0]  payload;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_DAT,
        ST_BASE,
        ST_DIV,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT,
        ST_FINAL
    } state_t;

endpackage

/* hw/rtl/looped_event_pattern_scheduler_core.sv */
// ----------------------------------------------------------------------------
// looped_event_pattern_scheduler_core
// Sorted timed-event table with clear, append and looped range query.
// ----------------------------------------------------------------------------
// Timing: one word is handled at a time; in_stall is high until it is done.
// Clear and unused codes go straight back to idle. Append walks the table with one
// memory read and compare per entry moved. A query with loop_length zero
// scans the table once, reading and comparing each entry and handing each
// hit to the output. With looping on, each stored tick first goes through a
// shared 32-step remainder unit and is insertion-sorted by its loop offset,
// then the range start is divided once more, then each loop copy of the
// table is scanned the same way; the output side can hold the scan with
// out_stall. The scan stops at the first copy at or past the range end or
// at the first hit found once OUT_CAP words are held. Ties keep load order.
module looped_event_pattern_scheduler_core #(
    parameter int PATTERN_DEPTH = leps_pkg::PATTERN_DEPTH_DEF,
    parameter int OUT_CAP       = leps_pkg::OUT_CAP_DEF,
    parameter int PAYLOAD_BITS  = leps_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  leps_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output leps_pkg::out_word_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int CW = $clog2(PATTERN_DEPTH + 1);
    localparam int NW = $clog2(OUT_CAP + 1);
    localparam int PW = leps_pkg::PAY_W;
    localparam int TW = leps_pkg::TICK_W;
    localparam int PB = (PAYLOAD_BITS < PW) ? PAYLOAD_BITS : PW;
    localparam logic [PW-1:0] PAY_MASK = {PW{1'b1}} >> (PW - PB);

    leps_pkg::state_t state_reg, state_next;

    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   sidx_reg, sidx_next;
    logic [TW-1:0]   loop_reg, loop_next;
    logic [TW-1:0]   key_reg, key_next;
    logic [PW-1:0]   pay_reg, pay_next;
    logic [TW-1:0]   start_reg, start_next;
    logic [TW-1:0]   end_reg, end_next;
    logic [TW+1:0]   base_reg, base_next;
    logic [TW-1:0]   dvd_reg, dvd_next;
    logic [TW-1:0]   rem_reg, rem_next;
    logic [4:0]      dcnt_reg, dcnt_next;
    logic            div_base_reg, div_base_next;
    logic            in_srt_reg, in_srt_next;
    logic [NW-1:0]   ncnt_reg, ncnt_next;
    logic            pend_valid_reg, pend_valid_next;
    leps_pkg::out_word_t pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    leps_pkg::out_word_t out_reg, out_next;

    leps_pkg::entry_t pat_mem [PATTERN_DEPTH];
    leps_pkg::entry_t srt_mem [PATTERN_DEPTH];
    leps_pkg::entry_t pat_rd_reg, srt_rd_reg;
    logic [IW-1:0]    raddr;
    logic             pat_we, srt_we;
    logic [IW-1:0]    waddr;
    leps_pkg::entry_t wdata;

    logic             in_acc, out_free;
    leps_pkg::entry_t src, ins_src;
    logic [TW+1:0]    abs_t, base_inc;
    logic [CW-1:0]    ptr_inc, ptr_dec, sidx_inc;
    logic             scan_wrap, scan_over, hit_end, hit, ins_move, sort_last;
    logic [TW:0]      div_r, div_rem;
    logic             div_done;
    leps_pkg::out_word_t cand;
    leps_pkg::state_t ins_done_state;

    assign in_stall  = (state_reg != leps_pkg::ST_IDLE);
    assign in_acc    = in_valid && (state_reg == leps_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        src       = (loop_reg == '0) ? pat_rd_reg : srt_rd_reg;
        ins_src   = in_srt_reg ? srt_rd_reg : pat_rd_reg;
        abs_t     = base_reg + {2'b00, src.tick};
        base_inc  = base_reg + {2'b00, loop_reg};
        ptr_inc   = ptr_reg + 1'b1;
        ptr_dec   = ptr_reg - 1'b1;
        sidx_inc  = sidx_reg + 1'b1;
        scan_wrap = (ptr_inc == cnt_reg);
        scan_over = scan_wrap && ((loop_reg == '0) || (base_inc >= {2'b00, end_reg}));
        hit_end   = (abs_t >= {2'b00, end_reg});
        hit       = !hit_end && (abs_t >= {2'b00, start_reg});
        ins_move  = (ins_src.tick > key_reg);
        sort_last = (sidx_inc == cnt_reg);
        div_r     = {rem_reg, dvd_reg[TW-1]};
        div_rem   = (div_r >= {1'b0, loop_reg}) ? (div_r - {1'b0, loop_reg}) : div_r;
        div_done  = (dcnt_reg == 5'd31);
        cand.status      = leps_pkg::STAT_EVENT;
        cand.out_tick    = abs_t[TW-1:0];
        cand.out_payload = src.payload;
        cand.last        = 1'b0;
        if (!in_srt_reg)
            ins_done_state = leps_pkg::ST_FINAL;
        else if (sort_last)
            ins_done_state = leps_pkg::ST_BASE;
        else
            ins_done_state = leps_pkg::ST_SORT_RD;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            leps_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_data.func)
                        leps_pkg::FN_APPEND:
                            state_next = (cnt_reg == CW'(PATTERN_DEPTH)) ?
                                         leps_pkg::ST_FINAL : leps_pkg::ST_INS_RD;
                        leps_pkg::FN_QUERY:
                        begin
                            if (in_data.range_start >= in_data.range_end || cnt_reg == '0)
                                state_next = leps_pkg::ST_IDLE;
                            else if (loop_reg == '0)
                                state_next = leps_pkg::ST_SCAN_RD;
                            else
                                state_next = leps_pkg::ST_SORT_RD;
                        end
                        default:
                            state_next = leps_pkg::ST_IDLE;
                    endcase
                end
            end
            leps_pkg::ST_SORT_RD:  state_next = leps_pkg::ST_SORT_DAT;
            leps_pkg::ST_SORT_DAT: state_next = leps_pkg::ST_DIV;
            leps_pkg::ST_BASE:     state_next = leps_pkg::ST_DIV;
            leps_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = div_base_reg ? leps_pkg::ST_SCAN_RD : leps_pkg::ST_INS_RD;
            end
            leps_pkg::ST_INS_RD:
                state_next = (ptr_reg == '0) ? ins_done_state : leps_pkg::ST_INS_CMP;
            leps_pkg::ST_INS_CMP:
                state_next = ins_move ? leps_pkg::ST_INS_RD : ins_done_state;
            leps_pkg::ST_SCAN_RD:  state_next = leps_pkg::ST_SCAN_CMP;
            leps_pkg::ST_SCAN_CMP:
            begin
                if (hit_end)
                    state_next = leps_pkg::ST_FINAL;
                else if (hit && pend_valid_reg && ncnt_reg == NW'(OUT_CAP))
                    state_next = leps_pkg::ST_FINAL;
                else if (hit && pend_valid_reg)
                    state_next = leps_pkg::ST_EMIT;
                else
                    state_next = scan_over ? leps_pkg::ST_FINAL : leps_pkg::ST_SCAN_RD;
            end
            leps_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = scan_over ? leps_pkg::ST_FINAL : leps_pkg::ST_SCAN_RD;
            end
            leps_pkg::ST_FINAL:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = leps_pkg::ST_IDLE;
            end
            default: state_next = leps_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        sidx_next       = sidx_reg;
        loop_next       = loop_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        base_next       = base_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        div_base_next   = div_base_reg;
        in_srt_next     = in_srt_reg;
        ncnt_next       = ncnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        raddr           = ptr_reg[IW-1:0];
        pat_we          = 1'b0;
        srt_we          = 1'b0;
        waddr           = ptr_reg[IW-1:0];
        wdata.tick      = key_reg;
        wdata.payload   = pay_reg;

        if (cfg_valid)
            loop_next = cfg_data;

        case (state_reg)
            leps_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_data.func)
                        leps_pkg::FN_CLEAR:
                            cnt_next = '0;
                        leps_pkg::FN_APPEND:
                        begin
                            key_next    = in_data.event_tick;
                            pay_next    = in_data.event_payload & PAY_MASK;
                            ptr_next    = cnt_reg;
                            in_srt_next = 1'b0;
                            if (cnt_reg == CW'(PATTERN_DEPTH))
                            begin
                                pend_next       = '0;
                                pend_next.status = leps_pkg::STAT_REJECT;
                                pend_valid_next = 1'b1;
                            end
                        end
                        leps_pkg::FN_QUERY:
                        begin
                            start_next      = in_data.range_start;
                            end_next        = in_data.range_end;
                            sidx_next       = '0;
                            ptr_next        = '0;
                            base_next       = '0;
                            ncnt_next       = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            leps_pkg::ST_SORT_RD:
                raddr = sidx_reg[IW-1:0];
            leps_pkg::ST_SORT_DAT:
            begin
                dvd_next      = pat_rd_reg.tick;
                pay_next      = pat_rd_reg.payload;
                rem_next      = '0;
                dcnt_next     = '0;
                div_base_next = 1'b0;
            end
            leps_pkg::ST_BASE:
            begin
                dvd_next      = start_reg;
                rem_next      = '0;
                dcnt_next     = '0;
                div_base_next = 1'b1;
            end
            leps_pkg::ST_DIV:
            begin
                rem_next  = div_rem[TW-1:0];
                dvd_next  = {dvd_reg[TW-2:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (div_done)
                begin
                    ptr_next = '0;
                    if (div_base_reg)
                        base_next = {2'b00, start_reg} - {2'b00, div_rem[TW-1:0]};
                    else
                    begin
                        key_next    = div_rem[TW-1:0];
                        ptr_next    = sidx_reg;
                        in_srt_next = 1'b1;
                    end
                end
            end
            leps_pkg::ST_INS_RD:
            begin
                raddr = ptr_dec[IW-1:0];
                if (ptr_reg == '0)
                begin
                    pat_we = !in_srt_reg;
                    srt_we = in_srt_reg;
                    if (in_srt_reg)
                        sidx_next = sidx_inc;
                    else
                    begin
                        cnt_next         = cnt_reg + 1'b1;
                        pend_next        = '0;
                        pend_next.status = leps_pkg::STAT_ACCEPT;
                        pend_valid_next  = 1'b1;
                    end
                end
            end
            leps_pkg::ST_INS_CMP:
            begin
                pat_we = !in_srt_reg;
                srt_we = in_srt_reg;
                if (ins_move)
                begin
                    wdata    = ins_src;
                    ptr_next = ptr_dec;
                end
                else if (in_srt_reg)
                    sidx_next = sidx_inc;
                else
                begin
                    cnt_next         = cnt_reg + 1'b1;
                    pend_next        = '0;
                    pend_next.status = leps_pkg::STAT_ACCEPT;
                    pend_valid_next  = 1'b1;
                end
            end
            leps_pkg::ST_SCAN_CMP:
            begin
                if (!hit_end)
                begin
                    if (hit && pend_valid_reg && ncnt_reg == NW'(OUT_CAP))
                        pend_next.status = leps_pkg::STAT_TRUNC;
                    else if (!(hit && pend_valid_reg))
                    begin
                        if (hit)
                        begin
                            pend_next       = cand;
                            pend_valid_next = 1'b1;
                            ncnt_next       = NW'(1);
                        end
                        if (scan_wrap)
                        begin
                            ptr_next  = '0;
                            base_next = base_inc;
                        end
                        else
                            ptr_next = ptr_inc;
                    end
                end
            end
            leps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    pend_next      = cand;
                    ncnt_next      = ncnt_reg + 1'b1;
                    if (scan_wrap)
                    begin
                        ptr_next  = '0;
                        base_next = base_inc;
                    end
                    else
                        ptr_next = ptr_inc;
                end
            end
            leps_pkg::ST_FINAL:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= leps_pkg::ST_IDLE;
            cnt_reg        <= '0;
            loop_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            loop_reg       <= loop_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        sidx_reg     <= sidx_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        base_reg     <= base_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        div_base_reg <= div_base_next;
        in_srt_reg   <= in_srt_next;
        ncnt_reg     <= ncnt_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // pattern table and loop-offset sorted copy
    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[waddr] <= wdata;
        pat_rd_reg <= pat_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (srt_we)
            srt_mem[waddr] <= wdata;
        srt_rd_reg <= srt_mem[raddr];
    end

endmodule
